// File: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared constants and types of the SQL script tokenizer
// Lexer modes, token kinds, event and error codes, brace keyword codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int ModeW = 5;
    localparam logic [ModeW-1:0] M_IDLE    = 5'd0;
    localparam logic [ModeW-1:0] M_PMINUS  = 5'd1;
    localparam logic [ModeW-1:0] M_PSLASH  = 5'd2;
    localparam logic [ModeW-1:0] M_PLT     = 5'd3;
    localparam logic [ModeW-1:0] M_PGT     = 5'd4;
    localparam logic [ModeW-1:0] M_PDOT    = 5'd5;
    localparam logic [ModeW-1:0] M_LINE    = 5'd6;
    localparam logic [ModeW-1:0] M_BLK     = 5'd7;
    localparam logic [ModeW-1:0] M_BLKSTAR = 5'd8;
    localparam logic [ModeW-1:0] M_STR     = 5'd9;
    localparam logic [ModeW-1:0] M_STRQ    = 5'd10;
    localparam logic [ModeW-1:0] M_BRKW    = 5'd11;
    localparam logic [ModeW-1:0] M_BRSP1   = 5'd12;
    localparam logic [ModeW-1:0] M_BRBODY  = 5'd13;
    localparam logic [ModeW-1:0] M_BRSP2   = 5'd14;
    localparam logic [ModeW-1:0] M_NUM     = 5'd15;
    localparam logic [ModeW-1:0] M_IDENT   = 5'd16;

    localparam logic [4:0] K_NUM = 5'd0, K_STR = 5'd1, K_DATE = 5'd2, K_TS = 5'd3;
    localparam logic [4:0] K_IDENT = 5'd4, K_LPAREN = 5'd5, K_RPAREN = 5'd6;
    localparam logic [4:0] K_COMMA = 5'd7, K_SEMI = 5'd8, K_DOT = 5'd9;
    localparam logic [4:0] K_PLUS = 5'd10, K_MINUS = 5'd11, K_STAR = 5'd12;
    localparam logic [4:0] K_SLASH = 5'd13, K_PERCENT = 5'd14, K_EQ = 5'd15;
    localparam logic [4:0] K_NE = 5'd16, K_LT = 5'd17, K_LE = 5'd18;
    localparam logic [4:0] K_GT = 5'd19, K_GE = 5'd20, K_END = 5'd21;

    localparam logic [1:0] EV_PAYLOAD = 2'd0, EV_TOKEN = 2'd1, EV_ERROR = 2'd2;

    localparam logic [2:0] E_OPEN_BLK = 3'd0, E_OPEN_STR = 3'd1, E_BAD_BRACE = 3'd2;
    localparam logic [2:0] E_OPEN_BRACE = 3'd3, E_NO_BRACE = 3'd4, E_BAD_CHAR = 3'd5;

    localparam logic [2:0] BK_EMPTY = 3'd0, BK_D = 3'd1, BK_T = 3'd2, BK_TS = 3'd3;
    localparam logic [2:0] BK_BAD = 3'd4;

    localparam logic [7:0] CH_AT = 8'h40, CH_US = 8'h5F, CH_PCT = 8'h25;
    localparam logic [7:0] CH_LBR = 8'h7B, CH_RBR = 8'h7D, CH_QUOTE = 8'h27;

    // One result: event, kind, position, value, error code.
    typedef struct packed {
        logic [1:0]  ev;
        logic [4:0]  kind;
        logic [16:0] pos;
        logic [7:0]  val;
        logic [2:0]  err;
    } t_res;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sql_script_tokenizer.sv
// ----------------------------------------------------------------------------
// sql_script_tokenizer
// Streaming SQL lexer: one source byte per transaction in, payload bytes,
// token records, errors and an End token out.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata fields (low bit first)                 tuser / tlast
// s_axis    in   src_byte[7:0]                                tuser req_type
// m_axis    out  kind,pos,value,upper,err (see port comment)  tuser event_res,
//                                                             tlast last_of_run
// Each input transaction is lexed by a single mode transition with one
// byte of lookahead, which decides up to two results; these are registered
// into a two-entry output buffer. Input is taken whenever the buffer will
// have room for both, so while the sink keeps up a byte is accepted every
// cycle as long as each gives at most one result, and a byte that gives two
// holds the input until the sink has taken one of them. Reset (synchronous,
// active low) returns the lexer to idle and empties the buffer. A stalled
// sink holds the head result and back-pressures input.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_script_tokenizer #(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // src_byte[7:0]
    input  wire logic        s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // token_kind[4:0], position[21:5], value_byte[29:22], upper_byte[37:30],
    // error_code[40:38], zero fill [47:41]
    output logic [47:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // event_res
    output logic             m_axis_tlast    // last_of_run
);
    import sst_pkg::*;

    localparam int OffW = $clog2(MAX_SOURCE_BYTES + 1);

    logic [ModeW-1:0] r_mode, n_mode;
    logic [OffW-1:0]  r_off, n_off;
    logic [OffW-1:0]  r_start, n_start;
    logic [2:0]       r_bk, n_bk;
    logic             r_halt, n_halt;

    t_res   r_q0, r_q1;
    logic   r_l0, r_l1;
    logic [1:0] r_cnt;

    t_res   res0, res1;
    logic [1:0] nres;
    logic   in_acc, out_acc;

    logic [7:0]  c;
    logic [16:0] pos_c, start_c;

    assign c       = s_axis_tdata;
    assign pos_c   = 17'(r_off);
    assign start_c = 17'(r_start);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    // Room for two results after this cycle's pop.
    assign s_axis_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && m_axis_tready);

    function automatic t_res mk(input logic [1:0] ev, input logic [4:0] k,
                                input logic [16:0] p, input logic [7:0] v,
                                input logic [2:0] e);
        t_res r;
        r.ev = ev; r.kind = k; r.pos = p;
        r.val = (ev == EV_PAYLOAD) ? v : 8'd0;
        r.err = (ev == EV_ERROR) ? e : 3'd0;
        return r;
    endfunction

    always_comb begin
        t_res fr;
        logic fr_v, fr_fail;
        logic [ModeW-1:0] f_mode;
        logic f_start;
        logic [4:0] bkk;
        logic [7:0] lc;
        logic do_fresh, bk_ok;
        n_mode = r_mode; n_off = r_off; n_start = r_start; n_bk = r_bk;
        n_halt = r_halt;
        res0 = '0; res1 = '0; nres = 2'd0;
        fr = '0; fr_v = 1'b0; fr_fail = 1'b0; f_mode = M_IDLE; f_start = 1'b0;
        do_fresh = 1'b0;
        bkk = (r_bk == BK_D) ? K_DATE : K_TS;
        bk_ok = (r_bk == BK_D) || (r_bk == BK_T) || (r_bk == BK_TS);
        lc = c | 8'h20;

        // Decode of a byte seen between tokens.
        unique case (c)
            8'h20, 8'h09, 8'h0D, 8'h0A: ;
            8'h2D: begin f_mode = M_PMINUS; f_start = 1'b1; end
            8'h2F: begin f_mode = M_PSLASH; f_start = 1'b1; end
            8'h3C: begin f_mode = M_PLT; f_start = 1'b1; end
            8'h3E: begin f_mode = M_PGT; f_start = 1'b1; end
            8'h2E: begin f_mode = M_PDOT; f_start = 1'b1; end
            CH_QUOTE: begin f_mode = M_STR; f_start = 1'b1; end
            CH_LBR: begin f_mode = M_BRKW; f_start = 1'b1; end
            8'h28: begin fr = mk(EV_TOKEN, K_LPAREN, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            8'h29: begin fr = mk(EV_TOKEN, K_RPAREN, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            8'h2C: begin fr = mk(EV_TOKEN, K_COMMA, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            8'h3B: begin fr = mk(EV_TOKEN, K_SEMI, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            8'h2B: begin fr = mk(EV_TOKEN, K_PLUS, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            8'h2A: begin fr = mk(EV_TOKEN, K_STAR, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            CH_PCT: begin fr = mk(EV_TOKEN, K_PERCENT, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            8'h3D: begin fr = mk(EV_TOKEN, K_EQ, pos_c, 8'd0, 3'd0); fr_v = 1'b1; end
            default: begin
                if (is_digit(c)) begin
                    f_mode = M_NUM; f_start = 1'b1; fr_v = 1'b1;
                    fr = mk(EV_PAYLOAD, K_NUM, pos_c, c, 3'd0);
                end else if (is_alpha(c) || c == CH_US || c == CH_AT) begin
                    f_mode = M_IDENT; f_start = 1'b1; fr_v = 1'b1;
                    fr = mk(EV_PAYLOAD, K_IDENT, pos_c, c, 3'd0);
                end else begin
                    fr_v = 1'b1; fr_fail = 1'b1;
                    fr = mk(EV_ERROR, 5'd0, pos_c, 8'd0, E_BAD_CHAR);
                end
            end
        endcase

        if (in_acc) begin
            if (s_axis_tuser) begin
                if (!r_halt) begin
                    nres = 2'd1;
                    res0 = mk(EV_TOKEN, K_END, pos_c, 8'd0, 3'd0);
                    unique case (r_mode)
                        M_PMINUS: res0 = mk(EV_TOKEN, K_MINUS, start_c, 8'd0, 3'd0);
                        M_PSLASH: res0 = mk(EV_TOKEN, K_SLASH, start_c, 8'd0, 3'd0);
                        M_PLT:    res0 = mk(EV_TOKEN, K_LT, start_c, 8'd0, 3'd0);
                        M_PGT:    res0 = mk(EV_TOKEN, K_GT, start_c, 8'd0, 3'd0);
                        M_PDOT:   res0 = mk(EV_TOKEN, K_DOT, start_c, 8'd0, 3'd0);
                        M_STRQ:   res0 = mk(EV_TOKEN, K_STR, start_c, 8'd0, 3'd0);
                        M_NUM:    res0 = mk(EV_TOKEN, K_NUM, start_c, 8'd0, 3'd0);
                        M_IDENT:  res0 = mk(EV_TOKEN, K_IDENT, start_c, 8'd0, 3'd0);
                        M_BLK, M_BLKSTAR:
                            res0 = mk(EV_ERROR, 5'd0, start_c, 8'd0, E_OPEN_BLK);
                        M_STR:    res0 = mk(EV_ERROR, 5'd0, start_c, 8'd0, E_OPEN_STR);
                        M_BRKW, M_BRSP1:
                            res0 = mk(EV_ERROR, 5'd0, start_c, 8'd0, E_BAD_BRACE);
                        M_BRBODY: res0 = mk(EV_ERROR, 5'd0, start_c, 8'd0, E_OPEN_BRACE);
                        M_BRSP2:  res0 = mk(EV_ERROR, 5'd0, start_c, 8'd0, E_NO_BRACE);
                        default:  ;
                    endcase
                    if (res0.ev == EV_TOKEN && res0.kind != K_END) begin
                        nres = 2'd2;
                        res1 = mk(EV_TOKEN, K_END, pos_c, 8'd0, 3'd0);
                    end
                end
                n_mode = M_IDLE; n_off = '0; n_start = '0; n_bk = BK_EMPTY;
                n_halt = 1'b0;
            end else begin
                if (r_off < OffW'(MAX_SOURCE_BYTES)) n_off = r_off + 1'b1;
                if (!r_halt) begin
                    priority case (r_mode)
                        M_PMINUS: begin
                            if (c == 8'h2D) n_mode = M_LINE;
                            else begin
                                res0 = mk(EV_TOKEN, K_MINUS, start_c, 8'd0, 3'd0);
                                nres = 2'd1; do_fresh = 1'b1;
                            end
                        end
                        M_PSLASH: begin
                            if (c == 8'h2F) n_mode = M_LINE;
                            else if (c == 8'h2A) n_mode = M_BLK;
                            else begin
                                res0 = mk(EV_TOKEN, K_SLASH, start_c, 8'd0, 3'd0);
                                nres = 2'd1; do_fresh = 1'b1;
                            end
                        end
                        M_PLT: begin
                            nres = 2'd1; n_mode = M_IDLE;
                            if (c == 8'h3E) res0 = mk(EV_TOKEN, K_NE, start_c, 8'd0, 3'd0);
                            else if (c == 8'h3D)
                                res0 = mk(EV_TOKEN, K_LE, start_c, 8'd0, 3'd0);
                            else begin
                                res0 = mk(EV_TOKEN, K_LT, start_c, 8'd0, 3'd0);
                                do_fresh = 1'b1;
                            end
                        end
                        M_PGT: begin
                            nres = 2'd1; n_mode = M_IDLE;
                            if (c == 8'h3D) res0 = mk(EV_TOKEN, K_GE, start_c, 8'd0, 3'd0);
                            else begin
                                res0 = mk(EV_TOKEN, K_GT, start_c, 8'd0, 3'd0);
                                do_fresh = 1'b1;
                            end
                        end
                        M_PDOT: begin
                            nres = 2'd1;
                            if (is_digit(c)) begin
                                n_mode = M_NUM; nres = 2'd2;
                                res0 = mk(EV_PAYLOAD, K_NUM, start_c, 8'h2E, 3'd0);
                                res1 = mk(EV_PAYLOAD, K_NUM, start_c, c, 3'd0);
                            end else begin
                                res0 = mk(EV_TOKEN, K_DOT, start_c, 8'd0, 3'd0);
                                do_fresh = 1'b1;
                            end
                        end
                        M_LINE: if (c == 8'h0A) n_mode = M_IDLE;
                        M_BLK: if (c == 8'h2A) n_mode = M_BLKSTAR;
                        M_BLKSTAR: begin
                            if (c == 8'h2F) n_mode = M_IDLE;
                            else if (c != 8'h2A) n_mode = M_BLK;
                        end
                        M_STR: begin
                            if (c == CH_QUOTE) n_mode = M_STRQ;
                            else begin
                                res0 = mk(EV_PAYLOAD, K_STR, start_c, c, 3'd0);
                                nres = 2'd1;
                            end
                        end
                        M_STRQ: begin
                            nres = 2'd1;
                            if (c == CH_QUOTE) begin
                                n_mode = M_STR;
                                res0 = mk(EV_PAYLOAD, K_STR, start_c, CH_QUOTE, 3'd0);
                            end else begin
                                res0 = mk(EV_TOKEN, K_STR, start_c, 8'd0, 3'd0);
                                do_fresh = 1'b1;
                            end
                        end
                        M_BRKW, M_BRSP1: begin
                            if (r_mode == M_BRKW && is_alpha(c)) begin
                                if (r_bk == BK_EMPTY)
                                    n_bk = (lc == 8'h64) ? BK_D :
                                           ((lc == 8'h74) ? BK_T : BK_BAD);
                                else if (r_bk == BK_T && lc == 8'h73) n_bk = BK_TS;
                                else n_bk = BK_BAD;
                            end else if (c == 8'h20) n_mode = M_BRSP1;
                            else if (c == CH_QUOTE && bk_ok) n_mode = M_BRBODY;
                            else begin
                                res0 = mk(EV_ERROR, 5'd0, start_c, 8'd0, E_BAD_BRACE);
                                nres = 2'd1; n_halt = 1'b1; n_mode = M_IDLE;
                            end
                        end
                        M_BRBODY: begin
                            if (c == CH_QUOTE) n_mode = M_BRSP2;
                            else begin
                                res0 = mk(EV_PAYLOAD, bkk, start_c, c, 3'd0);
                                nres = 2'd1;
                            end
                        end
                        M_BRSP2: begin
                            if (c == CH_RBR) begin
                                res0 = mk(EV_TOKEN, bkk, start_c, 8'd0, 3'd0);
                                nres = 2'd1; n_mode = M_IDLE;
                            end else if (c != 8'h20) begin
                                res0 = mk(EV_ERROR, 5'd0, start_c, 8'd0, E_NO_BRACE);
                                nres = 2'd1; n_halt = 1'b1; n_mode = M_IDLE;
                            end
                        end
                        M_NUM: begin
                            nres = 2'd1;
                            if (is_digit(c) || c == 8'h2E)
                                res0 = mk(EV_PAYLOAD, K_NUM, start_c, c, 3'd0);
                            else begin
                                res0 = mk(EV_TOKEN, K_NUM, start_c, 8'd0, 3'd0);
                                do_fresh = 1'b1;
                            end
                        end
                        M_IDENT: begin
                            nres = 2'd1;
                            if (is_alpha(c) || is_digit(c) || c == CH_US)
                                res0 = mk(EV_PAYLOAD, K_IDENT, start_c, c, 3'd0);
                            else begin
                                res0 = mk(EV_TOKEN, K_IDENT, start_c, 8'd0, 3'd0);
                                do_fresh = 1'b1;
                            end
                        end
                        default: begin
                            do_fresh = 1'b1;
                            if (fr_v) begin res0 = fr; nres = 2'd1; end
                        end
                    endcase
                    if (do_fresh) begin
                        n_mode = f_mode;
                        if (f_start) n_start = r_off;
                        if (f_mode == M_BRKW) n_bk = BK_EMPTY;
                        if (fr_fail) n_halt = 1'b1;
                        if (nres == 2'd1 && r_mode != M_IDLE && fr_v) begin
                            res1 = fr; nres = 2'd2;
                        end
                    end
                end
            end
        end
    end

    // Two-entry output buffer; entry 0 is the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_off <= '0; r_start <= '0; r_bk <= BK_EMPTY;
            r_halt <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_mode <= n_mode; r_off <= n_off; r_start <= n_start; r_bk <= n_bk;
            r_halt <= n_halt;
            r_cnt <= r_cnt - {1'b0, out_acc} + nres;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [1:0] base;
        base = out_acc ? r_cnt - 2'd1 : r_cnt;
        if (nres != 2'd0 && base == 2'd0) begin
            r_q0 <= res0; r_l0 <= (nres == 2'd1);
            r_q1 <= res1; r_l1 <= 1'b1;
        end else if (nres != 2'd0) begin
            if (out_acc) begin r_q0 <= r_q1; r_l0 <= r_l1; end
            r_q1 <= res0; r_l1 <= 1'b1;
        end else if (out_acc) begin
            r_q0 <= r_q1; r_l0 <= r_l1;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tuser  = r_q0.ev;
    assign m_axis_tlast  = r_l0;
    assign m_axis_tdata  = {7'd0, r_q0.err, upcase(r_q0.val), r_q0.val, r_q0.pos,
                            r_q0.kind};

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("output buffer overfilled");
    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !s_axis_tready) else $error("input taken with full buffer");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (nres == 2'd0)) else $error("result after error");
    a_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser) |=> (r_off == '0 && r_mode == M_IDLE && !r_halt))
        else $error("end of source did not rewind");

endmodule

`default_nettype wire
